FILE: rtl/pfbr_pkg.sv
// Package for the paged framebuffer refresh block: panel geometry, command and
// refresh phase codes, controller opcodes and the sequencer state type.
// No dependencies.
package pfbr_pkg;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
   localparam int STORE_AW     = $clog2(STORE_BYTES);
   localparam int COL_W        = $clog2(PANEL_WIDTH);
   localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   // controller opcodes
   localparam logic [7:0] OP_PAGE      = 8'hB0;
   localparam logic [7:0] OP_COL_UPPER = 8'h10;
   localparam logic [7:0] OP_COL_LOWER = 8'h00;

   typedef enum logic [1:0] {
      CMD_SET_PIXEL  = 2'd0,
      CMD_GET_PIXEL  = 2'd1,
      CMD_WRITE_BYTE = 2'd2,
      CMD_REFRESH    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_PAGE  = 2'd0,
      PHASE_UPPER = 2'd1,
      PHASE_LOWER = 2'd2,
      PHASE_DATA  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

FILE: rtl/pfbr_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module pfbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/paged_framebuffer_refresh_top.sv
// Top level of the paged framebuffer refresh block: command decode,
// read-modify-write sequencer and refresh stream generator.
// Depends on pfbr_pkg and pfbr_ram.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------------------
//   request   | start high, busy low       | req_command, req_x_coord, req_y_coord,
//             |                            | req_pixel_on, req_byte_index, req_byte_value
//   response  | rsp_strobe, one cycle      | rsp_pixel_value, rsp_bus_valid,
//             |                            | rsp_bus_is_data, rsp_bus_byte, rsp_frame_done
//
// In each transaction the accept cycle issues the frame store read and the following
// cycle modifies and writes the byte back. The response strobe appears in the cycle
// after that, when the next transaction may already be taken. After reset a clearing
// pass writes zero to all STORE_BYTES (1024) bytes, one a cycle, with busy high. The
// receiver cannot stall; responses are never held.
module paged_framebuffer_refresh_top
   import pfbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_x_coord,
   input  logic [7:0]  req_y_coord,
   input  logic        req_pixel_on,
   input  logic [9:0]  req_byte_index,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_strobe,
   output logic        rsp_pixel_value,
   output logic        rsp_bus_valid,
   output logic        rsp_bus_is_data,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_frame_done
);

   // sequencer
   state_type state_ff, state_in;
   logic [STORE_AW-1:0] clear_addr_ff, clear_addr_in;
   logic accept;

   // captured transaction
   cmd_type             cmd_ff;
   logic [2:0]          bit_sel_ff;
   logic                pixel_on_ff;
   logic                in_range_ff;
   logic                index_ok_ff;
   logic [7:0]          byte_value_ff;
   logic [STORE_AW-1:0] addr_ff;

   // refresh position
   logic [PAGE_W-1:0] page_ff, page_in;
   phase_type         phase_ff, phase_in;
   logic [COL_W-1:0]  column_ff, column_in;

   // response registers
   logic       rsp_strobe_ff;
   logic       pixel_value_ff, pixel_value_in;
   logic       bus_valid_ff, bus_valid_in;
   logic       bus_is_data_ff, bus_is_data_in;
   logic [7:0] bus_byte_ff, bus_byte_in;
   logic       frame_done_ff, frame_done_in;

   // memory port
   logic                ram_wr_en;
   logic [STORE_AW-1:0] ram_wr_addr;
   logic [7:0]          ram_wr_data;
   logic [STORE_AW-1:0] ram_rd_addr;
   logic [7:0]          ram_rd_data;

   // decode at accept
   logic                req_in_range;
   logic                req_index_ok;
   logic [STORE_AW-1:0] pixel_addr;
   logic [STORE_AW-1:0] refresh_addr;
   logic [7:0]          bit_mask;
   logic                exec_write;

   assign accept = start && (state_ff == ST_IDLE);

   assign req_in_range = (32'(req_x_coord) < PANEL_WIDTH) && (32'(req_y_coord) < PANEL_HEIGHT);
   assign req_index_ok = 32'(req_byte_index) < STORE_BYTES;
   assign pixel_addr   = STORE_AW'(32'(req_y_coord[7:3]) * PANEL_WIDTH + 32'(req_x_coord));
   assign refresh_addr = STORE_AW'(32'(page_ff) * PANEL_WIDTH + 32'(column_ff));

   always_comb begin
      case (cmd_type'(req_command)) inside
         CMD_SET_PIXEL, CMD_GET_PIXEL: ram_rd_addr = pixel_addr;
         CMD_WRITE_BYTE:               ram_rd_addr = STORE_AW'(req_byte_index);
         default:                      ram_rd_addr = refresh_addr;
      endcase
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (32'(clear_addr_ff) == STORE_BYTES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs of the sequencer ----------------
   assign bit_mask   = 8'(1) << bit_sel_ff;
   assign exec_write = ((cmd_ff == CMD_SET_PIXEL) && in_range_ff)
                    || ((cmd_ff == CMD_WRITE_BYTE) && index_ok_ff);

   always_comb begin
      busy        = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = byte_value_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_addr_ff;
            ram_wr_data = 8'h00;
         end
         ST_IDLE: busy = 1'b0;
         ST_EXEC: begin
            ram_wr_en = exec_write;
            if (cmd_ff == CMD_SET_PIXEL) begin
               ram_wr_data = pixel_on_ff ? (ram_rd_data | bit_mask)
                                         : (ram_rd_data & ~bit_mask);
            end
         end
         default: busy = 1'b1;
      endcase
   end

   // ---------------- response and refresh position ----------------
   always_comb begin
      page_in        = page_ff;
      phase_in       = phase_ff;
      column_in      = column_ff;
      pixel_value_in = 1'b0;
      bus_valid_in   = 1'b0;
      bus_is_data_in = 1'b0;
      bus_byte_in    = 8'h00;
      frame_done_in  = 1'b0;
      case (cmd_ff)
         CMD_GET_PIXEL: pixel_value_in = in_range_ff && ram_rd_data[bit_sel_ff];
         CMD_REFRESH: begin
            bus_valid_in = 1'b1;
            unique case (phase_ff)
               PHASE_PAGE: begin
                  bus_byte_in = OP_PAGE | {4'h0, 4'(page_ff)};
                  phase_in    = PHASE_UPPER;
               end
               PHASE_UPPER: begin
                  bus_byte_in = OP_COL_UPPER;
                  phase_in    = PHASE_LOWER;
               end
               PHASE_LOWER: begin
                  bus_byte_in = OP_COL_LOWER;
                  phase_in    = PHASE_DATA;
                  column_in   = COL_W'(PANEL_WIDTH - 1);
               end
               default: begin
                  bus_is_data_in = 1'b1;
                  bus_byte_in    = ram_rd_data;
                  if (column_ff == '0) begin
                     phase_in  = PHASE_PAGE;
                     column_in = COL_W'(PANEL_WIDTH - 1);
                     if (32'(page_ff) + 1 >= PAGE_COUNT) begin
                        frame_done_in = 1'b1;
                        page_in       = '0;
                     end else begin
                        page_in = page_ff + 1'b1;
                     end
                  end else begin
                     column_in = column_ff - 1'b1;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         page_ff       <= '0;
         phase_ff      <= PHASE_PAGE;
         column_ff     <= COL_W'(PANEL_WIDTH - 1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_strobe_ff <= (state_ff == ST_EXEC);
         if (state_ff == ST_EXEC) begin
            page_ff   <= page_in;
            phase_ff  <= phase_in;
            column_ff <= column_in;
         end
      end
   end

   // transaction capture and response registers; payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= cmd_type'(req_command);
         bit_sel_ff    <= req_y_coord[2:0];
         pixel_on_ff   <= req_pixel_on;
         in_range_ff   <= req_in_range;
         index_ok_ff   <= req_index_ok;
         byte_value_ff <= req_byte_value;
         addr_ff       <= ram_rd_addr;
      end
      if (state_ff == ST_EXEC) begin
         pixel_value_ff <= pixel_value_in;
         bus_valid_ff   <= bus_valid_in;
         bus_is_data_ff <= bus_is_data_in;
         bus_byte_ff    <= bus_byte_in;
         frame_done_ff  <= frame_done_in;
      end
   end

   pfbr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pixel_value = pixel_value_ff;
   assign rsp_bus_valid   = bus_valid_ff;
   assign rsp_bus_is_data = bus_is_data_ff;
   assign rsp_bus_byte    = bus_byte_ff;
   assign rsp_frame_done  = frame_done_ff;

endmodule

FILE: tb/paged_framebuffer_refresh_top_test.sv
// Self-checking testbench for paged_framebuffer_refresh_top: a scoreboard class
// mirrors the frame store and refresh sequencer, and plain tasks drive commands.
// Depends on pfbr_pkg and the block's RTL.
module paged_framebuffer_refresh_top_test;
   import pfbr_pkg::*;

   // watchdog: cycles with no transaction on either side before the run is abandoned
   localparam int QUIET_LIMIT = 4000;
   // input transactions to send
   localparam int MIX_ITEMS   = 500;

   typedef struct packed {
      logic       pixel_value;
      logic       bus_valid;
      logic       bus_is_data;
      logic [7:0] bus_byte;
      logic       frame_done;
   } bus_response_type;

   // Mirror of the frame store plus the refresh sequencer; queues the response that
   // each accepted command should produce and checks the block's responses in order.
   class frame_scoreboard;
      logic [7:0]       frame_store [STORE_BYTES];
      phase_type        phase;
      int unsigned      page;
      int unsigned      column;
      bus_response_type pending_responses [$];
      int               errors;

      function new();
         foreach (frame_store[i]) frame_store[i] = 8'h00;
         phase  = PHASE_PAGE;
         page   = 0;
         column = PANEL_WIDTH - 1;
         errors = 0;
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction

      function void apply_command(cmd_type cmd, logic [7:0] x, logic [7:0] y, logic on,
                                  logic [9:0] idx, logic [7:0] val);
         bus_response_type r;
         bit               in_range;
         int unsigned      addr;
         logic [7:0]       mask;
         r        = '0;
         in_range = (x < PANEL_WIDTH) && (y < PANEL_HEIGHT);
         addr     = (int'(y) / 8) * PANEL_WIDTH + int'(x);
         mask     = 8'h01 << y[2:0];
         case (cmd)
            CMD_SET_PIXEL: begin
               if (in_range)
                  frame_store[addr] = on ? (frame_store[addr] | mask)
                                         : (frame_store[addr] & ~mask);
            end
            CMD_GET_PIXEL: begin
               if (in_range) r.pixel_value = frame_store[addr][y[2:0]];
            end
            CMD_WRITE_BYTE: begin
               if (idx < STORE_BYTES) frame_store[idx] = val;
            end
            default: begin
               r.bus_valid = 1'b1;
               case (phase)
                  PHASE_PAGE: begin
                     r.bus_byte = OP_PAGE | 8'(page & 15);
                     phase      = PHASE_UPPER;
                  end
                  PHASE_UPPER: begin
                     r.bus_byte = OP_COL_UPPER;
                     phase      = PHASE_LOWER;
                  end
                  PHASE_LOWER: begin
                     r.bus_byte = OP_COL_LOWER;
                     phase      = PHASE_DATA;
                     column     = PANEL_WIDTH - 1;
                  end
                  default: begin
                     addr          = page * PANEL_WIDTH + column;
                     r.bus_is_data = 1'b1;
                     r.bus_byte    = (addr < STORE_BYTES) ? frame_store[addr] : 8'h00;
                     if (column == 0) begin
                        phase  = PHASE_PAGE;
                        column = PANEL_WIDTH - 1;
                        if (page + 1 >= PAGE_COUNT) begin
                           r.frame_done = 1'b1;
                           page         = 0;
                        end else begin
                           page++;
                        end
                     end else begin
                        column--;
                     end
                  end
               endcase
            end
         endcase
         pending_responses.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_field(string name, int unsigned got, int unsigned want);
         if (got != want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      endtask

      task check_response(bus_response_type got);
         bus_response_type want;
         if (pending_responses.size() == 0) begin
            report("response strobe with no command outstanding");
         end else begin
            want = pending_responses.pop_front();
            check_field("pixel_value", got.pixel_value, want.pixel_value);
            check_field("bus_valid",   got.bus_valid,   want.bus_valid);
            check_field("bus_is_data", got.bus_is_data, want.bus_is_data);
            check_field("bus_byte",    got.bus_byte,    want.bus_byte);
            check_field("frame_done",  got.frame_done,  want.frame_done);
         end
      endtask
   endclass

   // every input starts at a known value; reset is held from time zero
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       start          = 1'b0;
   logic [1:0] req_command    = 2'b00;
   logic [7:0] req_x_coord    = 8'h00;
   logic [7:0] req_y_coord    = 8'h00;
   logic       req_pixel_on   = 1'b0;
   logic [9:0] req_byte_index = 10'h000;
   logic [7:0] req_byte_value = 8'h00;
   logic       busy;
   logic       rsp_strobe;
   logic       rsp_pixel_value;
   logic       rsp_bus_valid;
   logic       rsp_bus_is_data;
   logic [7:0] rsp_bus_byte;
   logic       rsp_frame_done;

   frame_scoreboard sb;
   int              quiet_cycles = 0;
   int              calm_left    = 0;
   int              items_sent   = 0;

   paged_framebuffer_refresh_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_pixel_on    (req_pixel_on),
      .req_byte_index  (req_byte_index),
      .req_byte_value  (req_byte_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_bus_valid   (rsp_bus_valid),
      .rsp_bus_is_data (rsp_bus_is_data),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_frame_done  (rsp_frame_done)
   );

   always #10 clock = ~clock;

   // Monitor: one process samples both channels at the edge, so the order of
   // noting a request and checking a response never hangs on scheduling.
   // Values read here are the pre-edge ones, as all drives are nonblocking.
   always @(posedge clock) begin
      bit active;
      active = 1'b0;
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_response('{rsp_pixel_value, rsp_bus_valid, rsp_bus_is_data,
                             rsp_bus_byte, rsp_frame_done});
         active = 1'b1;
      end
      if (!reset && start && busy === 1'b0) begin
         sb.apply_command(cmd_type'(req_command), req_x_coord, req_y_coord,
                          req_pixel_on, req_byte_index, req_byte_value);
         active = 1'b1;
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
   end

   // watchdog; also covers the clearing pass after reset
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // One transaction: random hold-off (none during a calm stretch), then present
   // the command and hold it until the edge where busy is low. When no gap
   // follows, start stays high so back-to-back items are offered.
   task automatic send_item(cmd_type cmd, logic [7:0] x, logic [7:0] y, logic on,
                            logic [9:0] idx, logic [7:0] val);
      int gap;
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_x_coord    <= x;
      req_y_coord    <= y;
      req_pixel_on   <= on;
      req_byte_index <= idx;
      req_byte_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   // unused fields carry random noise so the block is seen to ignore them
   task automatic draw_pixel(logic [7:0] x, logic [7:0] y, logic on);
      send_item(CMD_SET_PIXEL, x, y, on, 10'($urandom_range(0, 1023)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic read_pixel(logic [7:0] x, logic [7:0] y);
      send_item(CMD_GET_PIXEL, x, y, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic poke_byte(logic [9:0] idx, logic [7:0] val);
      send_item(CMD_WRITE_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), idx, val);
   endtask

   task automatic refresh_run(int n);
      repeat (n)
         send_item(CMD_REFRESH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                   8'($urandom_range(0, 255)));
   endtask

   initial begin
      int         kind;
      logic [7:0] x;
      logic [7:0] y;
      logic [9:0] idx;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, out-of-range pixels, raw writes and the first refresh bytes
      draw_pixel(8'd0, 8'd0, 1'b1);
      read_pixel(8'd0, 8'd0);
      draw_pixel(8'd127, 8'd63, 1'b1);
      read_pixel(8'd127, 8'd63);
      draw_pixel(8'd128, 8'd5, 1'b1);       // column just past the panel
      read_pixel(8'd128, 8'd5);
      draw_pixel(8'd3, 8'd64, 1'b1);        // row just past the panel
      read_pixel(8'd3, 8'd64);
      draw_pixel(8'd255, 8'd255, 1'b1);
      read_pixel(8'd255, 8'd255);
      draw_pixel(8'd127, 8'd63, 1'b0);
      read_pixel(8'd127, 8'd63);
      poke_byte(10'd1023, 8'hFF);           // last byte of the store
      read_pixel(8'd127, 8'd63);
      poke_byte(10'd127, 8'h5A);            // first data byte of the refresh stream
      poke_byte(10'd0, 8'h00);
      read_pixel(8'd0, 8'd0);
      refresh_run(5);                       // page, upper, lower, two data bytes
      poke_byte(10'd512, 8'h80);
      read_pixel(8'd0, 8'd39);
      draw_pixel(8'd0, 8'd32, 1'b1);

      // random: draw/read-back and poke/read-back sequences with refresh bursts in
      // between, some out-of-range and free-form noise
      while (items_sent < MIX_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            refresh_run($urandom_range(1, 40));
         end else if (kind < 50) begin
            x = 8'($urandom_range(0, PANEL_WIDTH - 1));
            y = 8'($urandom_range(0, PANEL_HEIGHT - 1));
            draw_pixel(x, y, 1'($urandom_range(0, 1)));
            read_pixel(x, y);
         end else if (kind < 65) begin
            idx = 10'($urandom_range(0, STORE_BYTES - 1));
            poke_byte(idx, 8'($urandom_range(0, 255)));
            x = 8'(idx % PANEL_WIDTH);
            y = 8'((idx / PANEL_WIDTH) * 8 + $urandom_range(0, 7));
            read_pixel(x, y);
         end else if (kind < 80) begin
            read_pixel(8'($urandom_range(0, PANEL_WIDTH - 1)),
                       8'($urandom_range(0, PANEL_HEIGHT - 1)));
         end else if (kind < 90) begin
            x = 8'($urandom_range(0, 255));
            y = 8'($urandom_range(PANEL_HEIGHT, 255));
            if ($urandom_range(0, 1)) begin
               x = 8'($urandom_range(PANEL_WIDTH, 255));
               y = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 1)) draw_pixel(x, y, 1'($urandom_range(0, 1)));
            else read_pixel(x, y);
         end else begin
            send_item(cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
         end
      end
      start <= 1'b0;

      // drain, then wait for any stray strobe to show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pfbr_pkg.sv
rtl/pfbr_ram.sv
rtl/paged_framebuffer_refresh_top.sv
tb/paged_framebuffer_refresh_top_test.sv
